// ===== rtl/core/msp_pkg.sv =====
package msp_pkg;

  localparam int MAX_ROWS   = 8;
  localparam int MAX_COLS   = 8;
  localparam int VALUE_BITS = 32;

  // fixed port widths
  localparam int ELEM_BITS  = 32;
  localparam int IDX_OUT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_RW = $clog2(MAX_ROWS + 1);
  localparam int CNT_CW = $clog2(MAX_COLS + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_RW-1:0]            rcnt_t;
  typedef logic [CNT_CW-1:0]            ccnt_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    value_t data;
  } wr_req_t;

  typedef struct packed {
    logic  start;
    rcnt_t rows;
    ccnt_t cols;
  } scan_cmd_t;

  typedef struct packed {
    logic   found;
    value_t value;
    rcnt_t  row;
    ccnt_t  col;
    logic   last_flag;
  } result_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_FETCH,
    SC_LATCH,
    SC_ROW,
    SC_COL,
    SC_NEXT,
    SC_DONE
  } scan_state_t;

  function automatic addr_t cell_addr(input rcnt_t r, input ccnt_t c);
    return ADDR_W'(r[ROW_W-1:0]) * ADDR_W'(MAX_COLS) + ADDR_W'(c[COL_W-1:0]);
  endfunction

  // size 0 acts as 1, oversize acts as the maximum
  function automatic rcnt_t clamp_rows(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return rcnt_t'(1);
    else if (int'(v) > MAX_ROWS) return rcnt_t'(MAX_ROWS);
    else return rcnt_t'(v);
  endfunction

  function automatic ccnt_t clamp_cols(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return ccnt_t'(1);
    else if (int'(v) > MAX_COLS) return ccnt_t'(MAX_COLS);
    else return ccnt_t'(v);
  endfunction

  // truncate or sign-extend the input word to the stored width
  function automatic value_t to_value(input logic [ELEM_BITS-1:0] e);
    value_t v;
    int     j;
    for (int i = 0; i < VALUE_BITS; i++) begin
      j = (i < ELEM_BITS) ? i : ELEM_BITS - 1;
      v[i] = e[j];
    end
    return v;
  endfunction

  function automatic logic [ELEM_BITS-1:0] from_value(input value_t v);
    logic [ELEM_BITS-1:0] o;
    int                   j;
    for (int i = 0; i < ELEM_BITS; i++) begin
      j = (i < VALUE_BITS) ? i : 0;
      o[i] = (i < VALUE_BITS) ? v[j] : 1'b0;
    end
    return o;
  endfunction

  function automatic logic [IDX_OUT_W-1:0] row_out(input rcnt_t r);
    logic [IDX_OUT_W-1:0] o;
    int                   j;
    for (int i = 0; i < IDX_OUT_W; i++) begin
      j = (i < CNT_RW) ? i : 0;
      o[i] = (i < CNT_RW) ? r[j] : 1'b0;
    end
    return o;
  endfunction

  function automatic logic [IDX_OUT_W-1:0] col_out(input ccnt_t c);
    logic [IDX_OUT_W-1:0] o;
    int                   j;
    for (int i = 0; i < IDX_OUT_W; i++) begin
      j = (i < CNT_CW) ? i : 0;
      o[i] = (i < CNT_CW) ? c[j] : 1'b0;
    end
    return o;
  endfunction

endpackage

// ===== rtl/core/msp_store.sv =====
module msp_store (
  input  logic             clk,
  input  msp_pkg::wr_req_t wr,
  input  logic             rd_en,
  input  msp_pkg::addr_t   rd_addr,
  output msp_pkg::value_t  rd_data
);
  import msp_pkg::*;

  value_t mem [DEPTH];
  value_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/msp_scan.sv =====
module msp_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  msp_pkg::scan_cmd_t cmd,
  output logic               busy,
  output logic               rd_en,
  output msp_pkg::addr_t     rd_addr,
  input  msp_pkg::value_t    rd_data,
  output logic               res_strobe,
  output msp_pkg::result_t   res
);
  import msp_pkg::*;

  scan_state_t state_r, state_nxt;

  rcnt_t   rows_r, rows_nxt;
  ccnt_t   cols_r, cols_nxt;
  rcnt_t   r_r, r_nxt;
  ccnt_t   c_r, c_nxt;
  ccnt_t   kc_r, kc_nxt;
  rcnt_t   kr_r, kr_nxt;
  value_t  x_r, x_nxt;
  logic    pend_valid_r, pend_valid_nxt;
  result_t pend_r, pend_nxt;
  logic    strobe_r, strobe_nxt;
  result_t res_r, res_nxt;

  // shared compare unit: row pass tests elem > x, column pass tests x > elem
  value_t cmp_a, cmp_b;
  logic   cmp_gt;
  logic   last_kc, last_kr, last_c, last_r;

  assign cmp_a   = (state_r == SC_COL) ? x_r : rd_data;
  assign cmp_b   = (state_r == SC_COL) ? rd_data : x_r;
  assign cmp_gt  = cmp_a > cmp_b;
  assign last_kc = (kc_r + ccnt_t'(1)) == cols_r;
  assign last_kr = (kr_r + rcnt_t'(1)) == rows_r;
  assign last_c  = (c_r + ccnt_t'(1)) == cols_r;
  assign last_r  = (r_r + rcnt_t'(1)) == rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      strobe_r     <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rows_r <= rows_nxt;
    cols_r <= cols_nxt;
    r_r    <= r_nxt;
    c_r    <= c_nxt;
    kc_r   <= kc_nxt;
    kr_r   <= kr_nxt;
    x_r    <= x_nxt;
    pend_r <= pend_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    rows_nxt       = rows_r;
    cols_nxt       = cols_r;
    r_nxt          = r_r;
    c_nxt          = c_r;
    kc_nxt         = kc_r;
    kr_nxt         = kr_r;
    x_nxt          = x_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    strobe_nxt     = 1'b0;
    res_nxt        = res_r;
    rd_en          = 1'b0;
    rd_addr        = cell_addr(r_r, c_r);

    case (state_r)
      SC_IDLE: begin
        if (cmd.start) begin
          rows_nxt       = cmd.rows;
          cols_nxt       = cmd.cols;
          r_nxt          = '0;
          c_nxt          = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = SC_FETCH;
        end
      end
      SC_FETCH: begin
        rd_en     = 1'b1;
        state_nxt = SC_LATCH;
      end
      SC_LATCH: begin
        x_nxt     = rd_data;
        kc_nxt    = '0;
        rd_en     = 1'b1;
        rd_addr   = cell_addr(r_r, '0);
        state_nxt = SC_ROW;
      end
      SC_ROW: begin
        if (cmp_gt) begin
          state_nxt = SC_NEXT;
        end else if (last_kc) begin
          kr_nxt    = '0;
          rd_en     = 1'b1;
          rd_addr   = cell_addr('0, c_r);
          state_nxt = SC_COL;
        end else begin
          kc_nxt  = kc_r + ccnt_t'(1);
          rd_en   = 1'b1;
          rd_addr = cell_addr(r_r, kc_r + ccnt_t'(1));
        end
      end
      SC_COL: begin
        if (cmp_gt) begin
          state_nxt = SC_NEXT;
        end else if (last_kr) begin
          // hold the newest hit back until we know whether it is the last one
          if (pend_valid_r) begin
            strobe_nxt = 1'b1;
            res_nxt    = pend_r;
          end
          pend_nxt       = '{found: 1'b1, value: x_r, row: r_r, col: c_r, last_flag: 1'b0};
          pend_valid_nxt = 1'b1;
          state_nxt      = SC_NEXT;
        end else begin
          kr_nxt  = kr_r + rcnt_t'(1);
          rd_en   = 1'b1;
          rd_addr = cell_addr(kr_r + rcnt_t'(1), c_r);
        end
      end
      SC_NEXT: begin
        if (last_c && last_r) begin
          state_nxt = SC_DONE;
        end else begin
          if (last_c) begin
            c_nxt = '0;
            r_nxt = r_r + rcnt_t'(1);
          end else begin
            c_nxt = c_r + ccnt_t'(1);
          end
          state_nxt = SC_FETCH;
        end
      end
      SC_DONE: begin
        strobe_nxt = 1'b1;
        if (pend_valid_r) begin
          res_nxt           = pend_r;
          res_nxt.last_flag = 1'b1;
        end else begin
          res_nxt = '{found: 1'b0, value: '0, row: '0, col: '0, last_flag: 1'b1};
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = SC_IDLE;
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != SC_IDLE);
  assign res_strobe = strobe_r;
  assign res        = res_r;

endmodule

// ===== rtl/core/matrix_saddle_point_finder_top.sv =====
// Saddle point search over a signed matrix.
// Load: one element per request (start high while busy is low) in row-major
// order, rows_in_use x cols_in_use (0 acts as 1, oversize acts as 8). Loading
// runs at one element per cycle with busy low.
// The final element starts a scan: busy rises the next cycle and stays high
// until the last result. Each cell is fetched and latched, then its row is read
// until a larger row element ends it and, if none does, its column until a
// smaller column element ends it, all on one memory read port and one comparator.
// Results: one out_strobe pulse per saddle point in row-major order, the last
// one with out_last_result; with none, a single not-found result, also last.
// The final result shows in the cycle busy falls; a new matrix may start then.
// The receiver cannot stall: every strobe is taken in its own cycle.
// Config: cfg_valid with cfg_index/cfg_data, always ready; index 0 rows,
// 1 columns. A write to either restarts loading at row 0, column 0; write only while
// idle. Reset: sizes 3 x 4, load position 0, no results pending. The store
// needs no clearing pass.
module matrix_saddle_point_finder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_element_value,
  output logic               out_strobe,
  output logic               out_found,
  output logic signed [31:0] out_point_value,
  output logic [2:0]         out_row_index,
  output logic [2:0]         out_col_index,
  output logic               out_last_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);
  import msp_pkg::*;

  logic [CFG_DATA_W-1:0] rows_cfg_r, rows_cfg_nxt;
  logic [CFG_DATA_W-1:0] cols_cfg_r, cols_cfg_nxt;
  rcnt_t load_row_r, load_row_nxt;
  ccnt_t load_col_r, load_col_nxt;

  rcnt_t     rows_eff, row_eff;
  ccnt_t     cols_eff, col_eff;
  logic      accept, cfg_wr, out_of_range;
  wr_req_t   wr;
  scan_cmd_t cmd;
  logic      rd_en;
  addr_t     rd_addr;
  value_t    rd_data;
  logic      scan_busy;
  logic      res_strobe;
  result_t   res;

  assign cfg_ready    = 1'b1;
  assign cfg_wr       = cfg_valid && cfg_ready;
  assign accept       = start && !scan_busy;
  assign rows_eff     = clamp_rows(rows_cfg_r);
  assign cols_eff     = clamp_cols(cols_cfg_r);
  assign out_of_range = (load_row_r >= rows_eff) || (load_col_r >= cols_eff);
  assign row_eff      = out_of_range ? '0 : load_row_r;
  assign col_eff      = out_of_range ? '0 : load_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_DATA_W'(3);
      cols_cfg_r <= CFG_DATA_W'(4);
      load_row_r <= '0;
      load_col_r <= '0;
    end else begin
      rows_cfg_r <= rows_cfg_nxt;
      cols_cfg_r <= cols_cfg_nxt;
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
    end
  end

  always_comb begin
    rows_cfg_nxt = rows_cfg_r;
    cols_cfg_nxt = cols_cfg_r;
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    cmd.start    = 1'b0;
    cmd.rows     = rows_eff;
    cmd.cols     = cols_eff;
    wr.en        = accept;
    wr.addr      = cell_addr(row_eff, col_eff);
    wr.data      = to_value(in_element_value);

    if (accept) begin
      if ((col_eff + ccnt_t'(1)) != cols_eff) begin
        load_row_nxt = row_eff;
        load_col_nxt = col_eff + ccnt_t'(1);
      end else begin
        load_col_nxt = '0;
        if ((row_eff + rcnt_t'(1)) != rows_eff) begin
          load_row_nxt = row_eff + rcnt_t'(1);
        end else begin
          load_row_nxt = '0;
          cmd.start    = 1'b1;
        end
      end
    end

    if (cfg_wr && (cfg_index == CFG_ROWS || cfg_index == CFG_COLS)) begin
      if (cfg_index == CFG_ROWS) begin
        rows_cfg_nxt = cfg_data;
      end else begin
        cols_cfg_nxt = cfg_data;
      end
      load_row_nxt = '0;
      load_col_nxt = '0;
    end
  end

  msp_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  msp_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .busy       (scan_busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res_strobe (res_strobe),
    .res        (res)
  );

  assign busy            = scan_busy;
  assign out_strobe      = res_strobe;
  assign out_found       = res.found;
  assign out_point_value = from_value(res.value);
  assign out_row_index   = row_out(res.row);
  assign out_col_index   = col_out(res.col);
  assign out_last_result = res.last_flag;

endmodule

// ===== rtl/core/msp_checker.sv =====
module msp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_found,
  input logic [31:0] out_point_value,
  input logic [2:0]  out_row_index,
  input logic [2:0]  out_col_index,
  input logic        out_last_result
);

  // a not-found result is always the only, and so the last, one
  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_found |-> out_last_result)
    else $error("not-found result without last flag");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_found |->
      out_point_value == 32'd0 && out_row_index == 3'd0 && out_col_index == 3'd0)
    else $error("not-found result carries nonzero fields");

  // early results come out mid-scan, the final one as the scan ends
  a_early_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_result |-> busy)
    else $error("non-final result outside a scan");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_strobe && out_last_result)
    else $error("scan ended without a final result");

endmodule

bind matrix_saddle_point_finder_top msp_checker u_msp_checker (.*);

// ===== tb/matrix_saddle_point_finder_top_tb.sv =====
module matrix_saddle_point_finder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int ELEMENT_TARGET = 400;
  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic             found;
    value_t           value;
    logic [2:0]       row;
    logic [2:0]       col;
    logic             last;
  } point_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  value_t             in_element_value;
  logic               out_strobe;
  logic               out_found;
  logic signed [31:0] out_point_value;
  logic [2:0]         out_row_index;
  logic [2:0]         out_col_index;
  logic               out_last_result;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [3:0]         cfg_data;

  // mirror of the block: loaded matrix, sizes, load position
  value_t                grid [MAX_ROWS][MAX_COLS];
  logic [CFG_DATA_W-1:0] rows_cfg;
  logic [CFG_DATA_W-1:0] cols_cfg;
  int                    load_row;
  int                    load_col;

  point_t pending_points[$];
  int     mismatches = 0;
  int     elements_sent = 0;
  int     idle_cycles = 0;

  matrix_saddle_point_finder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_element_value (in_element_value),
    .out_strobe       (out_strobe),
    .out_found        (out_found),
    .out_point_value  (out_point_value),
    .out_row_index    (out_row_index),
    .out_col_index    (out_col_index),
    .out_last_result  (out_last_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int fit_size(input logic [CFG_DATA_W-1:0] v, input int cap);
    if (v == '0) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  function automatic bit is_saddle(input int r, input int c, input int nr, input int nc);
    for (int k = 0; k < nc; k++)
      if (grid[r][k] > grid[r][c]) return 1'b0;
    for (int k = 0; k < nr; k++)
      if (grid[k][c] < grid[r][c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 8);
  endfunction

  // store one element; the final element of a matrix yields the saddle list
  task automatic load_and_scan(input value_t v);
    int     nr;
    int     nc;
    int     hits;
    int     seen;
    point_t rec;
    nr = fit_size(rows_cfg, MAX_ROWS);
    nc = fit_size(cols_cfg, MAX_COLS);
    if (load_row >= nr || load_col >= nc) begin
      load_row = 0;
      load_col = 0;
    end
    grid[load_row][load_col] = v;
    if (load_col + 1 < nc) begin
      load_col++;
      return;
    end
    load_col = 0;
    if (load_row + 1 < nr) begin
      load_row++;
      return;
    end
    load_row = 0;
    hits = 0;
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        if (is_saddle(r, c, nr, nc)) hits++;
    seen = 0;
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        if (is_saddle(r, c, nr, nc)) begin
          seen++;
          rec.found = 1'b1;
          rec.value = grid[r][c];
          rec.row   = 3'(r);
          rec.col   = 3'(c);
          rec.last  = (seen == hits);
          pending_points.push_back(rec);
        end
    if (hits == 0) begin
      rec.found = 1'b0;
      rec.value = '0;
      rec.row   = '0;
      rec.col   = '0;
      rec.last  = 1'b1;
      pending_points.push_back(rec);
    end
  endtask

  // start stays high after acceptance so back-to-back requests need no gap
  task automatic send_element(input value_t v, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_element_value = v;
    do @(posedge clk); while (busy);
    load_and_scan(v);
    elements_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    start = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ROWS || idx == CFG_COLS) begin
      if (idx == CFG_ROWS) rows_cfg = data;
      else cols_cfg = data;
      load_row = 0;
      load_col = 0;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_list(input value_t vals[$]);
    foreach (vals[i]) send_element(vals[i], pick_gap(1'b0));
  endtask

  // reset size 3x4, extreme values, tied maxima giving four saddles
  task automatic test_default_size();
    value_t vals[$];
    vals = '{VAL_MIN, 5, 5, VAL_MIN,
             -1, 5, 5, -7,
             VAL_MAX, 9, 9, 0};
    send_list(vals);
    drain();
  endtask

  task automatic test_zero_and_oversize();
    value_t vals[$];
    write_reg(CFG_UNUSED, 4'hf);
    write_reg(CFG_ROWS, 4'd0);
    write_reg(CFG_COLS, 4'd0);
    send_element(-1, pick_gap(1'b0));
    drain();
    write_reg(CFG_COLS, 4'd15);
    vals = '{3, 7, -2, 7, 0, VAL_MIN, 7, 1};
    send_list(vals);
    drain();
  endtask

  // a write mid-load throws away the partial matrix
  task automatic test_restart_on_write();
    value_t vals[$];
    write_reg(CFG_ROWS, 4'd2);
    write_reg(CFG_COLS, 4'd1);
    send_element(100, pick_gap(1'b0));
    write_reg(CFG_COLS, 4'd1);
    vals = '{5, 4};
    send_list(vals);
    drain();
  endtask

  task automatic test_no_saddle();
    value_t vals[$];
    write_reg(CFG_ROWS, 4'd2);
    write_reg(CFG_COLS, 4'd2);
    vals = '{1, 2, 2, 1};
    send_list(vals);
    drain();
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 4'($urandom_range(1, 4));
    if (sel < 8) return 4'($urandom_range(5, 8));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic send_matrix();
    int     nr;
    int     nc;
    int     kind;
    int     pr;
    int     pc;
    int     base;
    bit     burst;
    value_t flat;
    value_t v;
    nr = fit_size(rows_cfg, MAX_ROWS);
    nc = fit_size(cols_cfg, MAX_COLS);
    kind = $urandom_range(0, 19);
    burst = ($urandom_range(0, 3) == 0);
    pr = $urandom_range(0, nr - 1);
    pc = $urandom_range(0, nc - 1);
    base = int'($urandom_range(0, 200)) - 100;
    flat = value_t'($urandom);
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++) begin
        if (kind < 5) v = value_t'($urandom);
        else if (kind < 10) v = value_t'(int'($urandom_range(0, 6)) - 3);
        else if (kind < 17) begin
          // planted saddle: its row no larger, its column no smaller
          if (r == pr && c == pc) v = base;
          else if (r == pr) v = base - int'($urandom_range(0, 2));
          else if (c == pc) v = base + int'($urandom_range(0, 2));
          else v = base + int'($urandom_range(0, 10)) - 5;
        end else v = flat;
        send_element(v, pick_gap(burst));
      end
  endtask

  task automatic test_random();
    int cells;
    while (elements_sent < ELEMENT_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        case ($urandom_range(0, 2))
          0: write_reg(CFG_ROWS, pick_size());
          1: write_reg(CFG_COLS, pick_size());
          default: begin
            write_reg(CFG_ROWS, pick_size());
            write_reg(CFG_COLS, pick_size());
          end
        endcase
      end
      if ($urandom_range(0, 11) == 0) begin
        // broken matrix: partial load cut short by a register write
        drain();
        cells = fit_size(rows_cfg, MAX_ROWS) * fit_size(cols_cfg, MAX_COLS);
        if (cells > 1)
          repeat ($urandom_range(1, cells - 1))
            send_element(value_t'($urandom), pick_gap(1'b0));
        drain();
        if ($urandom_range(0, 1) == 0) write_reg(CFG_ROWS, pick_size());
        else write_reg(CFG_COLS, pick_size());
      end
      send_matrix();
    end
  endtask

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_strobe) begin
      if (pending_points.size() == 0) begin
        $error("result with nothing pending: found=%0d value=%0d row=%0d col=%0d",
               out_found, out_point_value, out_row_index, out_col_index);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          mismatches++;
        end
        if (out_point_value !== want.value) begin
          $error("point_value: expected %0d, got %0d", want.value, out_point_value);
          mismatches++;
        end
        if (out_row_index !== want.row) begin
          $error("row_index: expected %0d, got %0d", want.row, out_row_index);
          mismatches++;
        end
        if (out_col_index !== want.col) begin
          $error("col_index: expected %0d, got %0d", want.col, out_col_index);
          mismatches++;
        end
        if (out_last_result !== want.last) begin
          $error("last_result: expected %0d, got %0d", want.last, out_last_result);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[matrix_saddle_point_finder_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_element_value = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rows_cfg = 4'd3;
    cols_cfg = 4'd4;
    load_row = 0;
    load_col = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_size();
    test_zero_and_oversize();
    test_restart_on_write();
    test_no_saddle();
    test_random();
    drain();
    repeat (20) @(negedge clk);

    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("[matrix_saddle_point_finder_top] OK");
    end else begin
      $display("[matrix_saddle_point_finder_top] ERROR");
    end
    $finish;
  end

endmodule
